@@ hdl/efa_pkg.sv @@
// ----------------------------------------------------------------------------
// efa_pkg
// Shared types and constants for the encoder frame accumulator.
// ----------------------------------------------------------------------------
package efa_pkg;

    // Fixed field widths
    localparam int BYTE_W     = 8;
    localparam int CHAN_W     = 3;
    localparam int OUT_POS_W  = 32;
    localparam int FRAME_CNT_W = 32;
    localparam int MASK_W     = 5;

    // Frame layout
    localparam int FIRST_DATA_BYTE = 4;
    localparam logic [BYTE_W-1:0] NEG_MARK = 8'h80;

    // Register reset: channel 3 inverted
    localparam logic [MASK_W-1:0] INVERT_RESET = 5'd8;

    // Defaults for the top level parameters
    localparam int DEF_NUM_CHANNELS   = 5;
    localparam int DEF_FRAME_BYTES    = 15;
    localparam int DEF_POSITION_WIDTH = 32;

    // Role of the byte currently in the process stage
    typedef struct packed {
        logic              frame_start;  // byte 0 of a frame
        logic              is_low;       // low byte of a channel delta
        logic              is_high;      // high byte of a channel delta
        logic [CHAN_W-1:0] chan;         // channel of a data byte
    } t_slot;

endpackage

@@ hdl/efa_seq.sv @@
// ----------------------------------------------------------------------------
// efa_seq
// Byte position within the frame, frame counter and decode of the byte role.
// ----------------------------------------------------------------------------
module efa_seq #(
    parameter int NUM_CHANNELS = efa_pkg::DEF_NUM_CHANNELS,
    parameter int FRAME_BYTES  = efa_pkg::DEF_FRAME_BYTES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_step,
    output efa_pkg::t_slot                   o_slot,
    output logic [efa_pkg::FRAME_CNT_W-1:0]  o_frame_count
);
    import efa_pkg::*;

    localparam int IDX_W = $clog2(FRAME_BYTES);
    localparam logic [IDX_W:0] DATA_LO = (IDX_W+1)'(FIRST_DATA_BYTE);
    localparam logic [IDX_W:0] DATA_HI = (IDX_W+1)'(FIRST_DATA_BYTE + 2*NUM_CHANNELS);
    localparam logic [IDX_W:0] FRAME_END = (IDX_W+1)'(FRAME_BYTES);

    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [FRAME_CNT_W-1:0] r_frames, n_frames;
    logic [IDX_W:0]         idx_ext;
    logic [IDX_W:0]         idx_inc;
    logic [IDX_W-1:0]       offset;
    logic                   in_data;

    // Decode the current byte position
    assign idx_ext = {1'b0, r_idx};
    assign in_data = (idx_ext >= DATA_LO) && (idx_ext < DATA_HI);
    assign offset  = r_idx - IDX_W'(FIRST_DATA_BYTE);

    always_comb begin
        o_slot.frame_start = (r_idx == '0);
        o_slot.is_low      = in_data && !offset[0];
        o_slot.is_high     = in_data && offset[0];
        o_slot.chan        = CHAN_W'(offset[IDX_W-1:1]);
    end

    // Count including the current frame
    assign n_frames      = o_slot.frame_start ? r_frames + 1'b1 : r_frames;
    assign o_frame_count = n_frames;

    // Next byte position, wraps at the frame length
    assign idx_inc = idx_ext + 1'b1;
    assign n_idx   = (idx_inc >= FRAME_END) ? '0 : idx_inc[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_frames <= '0;
        end else if (i_step) begin
            r_idx    <= n_idx;
            r_frames <= n_frames;
        end
    end

`ifndef ASSERT_OFF
    // Position never reaches the frame length
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_idx} < FRAME_END)
        else $error("byte index out of frame");

    // Sequencer state only moves on a processed byte
    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_idx) && $stable(r_frames))
        else $error("sequencer moved without a byte");
`endif

endmodule

@@ hdl/efa_acc.sv @@
// ----------------------------------------------------------------------------
// efa_acc
// Delta assembly, per-channel position accumulators and result register.
// ----------------------------------------------------------------------------
module efa_acc #(
    parameter int NUM_CHANNELS   = efa_pkg::DEF_NUM_CHANNELS,
    parameter int POSITION_WIDTH = efa_pkg::DEF_POSITION_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_step,
    input  logic [efa_pkg::BYTE_W-1:0]       i_byte,
    input  efa_pkg::t_slot                   i_slot,
    input  logic [efa_pkg::FRAME_CNT_W-1:0]  i_frame_count,
    input  logic [efa_pkg::MASK_W-1:0]       i_invert_mask,
    input  logic                             i_out_stall,
    output logic                             o_valid,
    output logic [efa_pkg::CHAN_W-1:0]       o_channel,
    output logic signed [efa_pkg::OUT_POS_W-1:0] o_position,
    output logic [efa_pkg::FRAME_CNT_W-1:0]  o_frame_count,
    output logic                             o_last
);
    import efa_pkg::*;

    localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int EXT_W = (POSITION_WIDTH > OUT_POS_W) ? POSITION_WIDTH : OUT_POS_W;
    localparam logic [CHAN_W-1:0] LAST_CHAN = CHAN_W'(NUM_CHANNELS - 1);

    logic [BYTE_W-1:0]         r_low;
    logic [POSITION_WIDTH-1:0] r_pos [NUM_CHANNELS];
    logic                      r_valid;
    logic [CHAN_W-1:0]         r_channel;
    logic [OUT_POS_W-1:0]      r_position;
    logic [FRAME_CNT_W-1:0]    r_frame_count;
    logic                      r_last;

    logic [CH_W-1:0]           ch_sel;
    logic [NUM_CHANNELS-1:0]   inv_bits;
    logic                      neg_mark;
    logic                      neg;
    logic [2*BYTE_W-1:0]       mag;
    logic [POSITION_WIDTH-1:0] mag_ext;
    logic [POSITION_WIDTH-1:0] n_pos;
    logic [EXT_W-1:0]          pos_ext;
    logic                      upd;

    // Delta from the held low byte and the arriving high byte
    assign ch_sel   = i_slot.chan[CH_W-1:0];
    assign inv_bits = i_invert_mask[NUM_CHANNELS-1:0];
    assign neg_mark = (i_byte == NEG_MARK);
    assign neg      = neg_mark ^ inv_bits[ch_sel];
    assign mag      = neg_mark ? {{BYTE_W{1'b0}}, r_low} : {i_byte, r_low};
    assign mag_ext  = POSITION_WIDTH'(mag);

    // One add or subtract per high byte
    assign n_pos   = neg ? r_pos[ch_sel] - mag_ext : r_pos[ch_sel] + mag_ext;
    assign pos_ext = EXT_W'(n_pos);
    assign upd     = i_step && i_slot.is_high;

    // Low byte holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low <= '0;
        end else if (i_step && i_slot.is_low) begin
            r_low <= i_byte;
        end
    end

    // Position accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_pos[c] <= '0;
            end
        end else if (upd) begin
            r_pos[ch_sel] <= n_pos;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (upd) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd) begin
            r_channel     <= i_slot.chan;
            r_position    <= pos_ext[OUT_POS_W-1:0];
            r_frame_count <= i_frame_count;
            r_last        <= (i_slot.chan == LAST_CHAN);
        end
    end

    assign o_valid       = r_valid;
    assign o_channel     = r_channel;
    assign o_position    = r_position;
    assign o_frame_count = r_frame_count;
    assign o_last        = r_last;

`ifndef ASSERT_OFF
    // A new result only follows a processed high byte
    a_rise_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_valid) |-> $past(upd))
        else $error("result without high byte");

    // A high byte lands in the result register with its channel
    a_land: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd |=> r_valid && (r_channel == $past(i_slot.chan)))
        else $error("high byte result lost");

    // Byte roles never overlap
    a_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_slot.is_low && i_slot.is_high))
        else $error("byte decoded as both low and high");
`endif

endmodule

@@ hdl/encoder_frame_accumulator.sv @@
// ----------------------------------------------------------------------------
// encoder_frame_accumulator
// Groups received bytes into fixed frames and accumulates encoder deltas.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while no result word is stalled. A byte passes an
// input register and is then processed by one add or subtract on the
// selected channel position, landing in the result register. Bytes 4 to
// 4+2*NUM_CHANNELS-1 of each frame carry low/high delta pairs; a high byte
// of 0x80 means minus the low byte, and the channel's invert_mask bit flips
// the sign. Each high byte yields one word with the channel, its updated
// position, the frame count and a last flag on the final channel. While a
// word waits in the stalled result register, the byte in the input register
// is held and the byte input stalls in the same cycle, so the output stall
// reaches the input stall combinationally. Write invert_mask only while idle.
// ----------------------------------------------------------------------------
module encoder_frame_accumulator #(
    parameter int NUM_CHANNELS   = efa_pkg::DEF_NUM_CHANNELS,
    parameter int FRAME_BYTES    = efa_pkg::DEF_FRAME_BYTES,
    parameter int POSITION_WIDTH = efa_pkg::DEF_POSITION_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Byte input
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [efa_pkg::BYTE_W-1:0]       i_rx_byte,
    // Result output
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [efa_pkg::CHAN_W-1:0]       o_channel,
    output logic signed [efa_pkg::OUT_POS_W-1:0] o_position,
    output logic [efa_pkg::FRAME_CNT_W-1:0]  o_frame_count,
    output logic                             o_last,
    // Configuration
    input  logic                             i_cfg_we,
    input  logic [efa_pkg::MASK_W-1:0]       i_cfg_wdata
);
    import efa_pkg::*;

    logic                   r_in_valid;
    logic [BYTE_W-1:0]      r_in_byte;
    logic [MASK_W-1:0]      r_invert_mask;
    logic                   step;
    logic                   accept;
    t_slot                  slot;
    logic [FRAME_CNT_W-1:0] frame_count;

    // Process stage advances on a held byte unless a finished word is stalled
    assign step       = r_in_valid && !(o_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && !step;
    assign accept     = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // Invert mask register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert_mask <= INVERT_RESET;
        end else if (i_cfg_we) begin
            r_invert_mask <= i_cfg_wdata;
        end
    end

    efa_seq #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .FRAME_BYTES  (FRAME_BYTES)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .o_slot        (slot),
        .o_frame_count (frame_count)
    );

    efa_acc #(
        .NUM_CHANNELS   (NUM_CHANNELS),
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_acc (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_byte        (r_in_byte),
        .i_slot        (slot),
        .i_frame_count (frame_count),
        .i_invert_mask (r_invert_mask),
        .i_out_stall   (i_out_stall),
        .o_valid       (o_out_valid),
        .o_channel     (o_channel),
        .o_position    (o_position),
        .o_frame_count (o_frame_count),
        .o_last        (o_last)
    );

endmodule
